// ===== sv/ada_lexical_normalizer_macros.svh =====
// assertion macros for the ada lexical normalizer checker
// no dependencies; included by the checker file
`ifndef ADA_LEXICAL_NORMALIZER_MACROS_SVH
`define ADA_LEXICAL_NORMALIZER_MACROS_SVH

// same-cycle implication, disabled during reset
`define ALN_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("aln: assertion failed");

// next-cycle implication, disabled during reset
`define ALN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("aln: assertion failed");

`endif

// ===== sv/aln_pkg.sv =====
// shared types and constants for the ada lexical normalizer
// no dependencies; used by every rtl module of the block
`timescale 1ns / 1ps
`default_nettype none

package aln_pkg;

	typedef logic [7:0] char_t;

	// identifier characters kept for keyword matching
	localparam int unsigned KeywordMaxChars = 7;

	// characters one queue word can carry (a final drain emits up to six)
	localparam int unsigned EntryChars = 6;
	localparam int unsigned EntryIdxW  = $clog2(EntryChars);
	localparam int unsigned EntryCntW  = $clog2(EntryChars + 1);

	localparam int unsigned FifoDepth = 4;
	localparam int unsigned FifoAw    = $clog2(FifoDepth);
	localparam int unsigned FifoCntW  = FifoAw + 1;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} byte_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       end_of_file;
	} lex_item_t;

	typedef struct packed {
		char_t [EntryChars-1:0] ch;
		logic  [EntryCntW-1:0]  cnt;
		logic                   eof;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

`default_nettype wire

// ===== sv/aln_front.sv =====
// front end: lookahead window, lexer state and token classification
// depends on aln_pkg; pushes character groups into aln_fifo
`timescale 1ns / 1ps
`default_nettype none

module aln_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  aln_pkg::byte_item_t byte_data,
	input  aln_pkg::fifo_stat_t fifo_stat,
	output logic                push,
	output aln_pkg::entry_t     push_data
);

	localparam int unsigned WordIdxW        = $clog2(aln_pkg::KeywordMaxChars);

	localparam aln_pkg::char_t ChNewline = 8'h0A;
	localparam aln_pkg::char_t ChSpace   = 8'h20;
	localparam aln_pkg::char_t ChQuote   = 8'h22;
	localparam aln_pkg::char_t ChHash    = 8'h23;
	localparam aln_pkg::char_t ChTick    = 8'h27;
	localparam aln_pkg::char_t ChDash    = 8'h2D;
	localparam aln_pkg::char_t ChDot     = 8'h2E;
	localparam aln_pkg::char_t ChSemi    = 8'h3B;
	localparam aln_pkg::char_t ChUnder   = 8'h5F;

	typedef enum logic [4:0] {
		MODE_IDLE    = 5'b00001,
		MODE_COMMENT = 5'b00010,
		MODE_STRING  = 5'b00100,
		MODE_IDENT   = 5'b01000,
		MODE_NUMBER  = 5'b10000
	} lex_mode_t;

	typedef enum logic [1:0] {
		F_RUN   = 2'b01,
		F_DRAIN = 2'b10
	} fsm_t;

	typedef aln_pkg::char_t [aln_pkg::KeywordMaxChars-1:0] word_t;

	typedef struct packed {
		lex_mode_t  mode;
		logic       prev_word;
		logic       prev_num;
		word_t      word;
		logic [3:0] wlen;
	} lex_state_t;

	typedef struct packed {
		lex_state_t            st;
		aln_pkg::char_t [2:0]  ch;
		logic [1:0]            n;
		logic [1:0]            k;
	} take_res_t;

	function automatic logic is_upper(input aln_pkg::char_t c);
		return c inside {[8'h41:8'h5A]};
	endfunction

	function automatic logic is_alpha(input aln_pkg::char_t c);
		return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
	endfunction

	function automatic logic is_digit(input aln_pkg::char_t c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_xdigit(input aln_pkg::char_t c);
		return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
	endfunction

	function automatic logic is_space(input aln_pkg::char_t c);
		return c inside {ChSpace, [8'h09:8'h0D]};
	endfunction

	function automatic aln_pkg::char_t to_lower(input aln_pkg::char_t c);
		return is_upper(c) ? c + 8'd32 : c;
	endfunction

	function automatic logic is_keyword(input word_t w, input logic [3:0] len);
		logic hit;
		hit = 1'b0;
		case (len)
			4'd2: hit = ({w[0], w[1]} == "is") || ({w[0], w[1]} == "do");
			4'd4: hit = ({w[0], w[1], w[2], w[3]} == "loop") ||
			            ({w[0], w[1], w[2], w[3]} == "then");
			4'd5: hit = ({w[0], w[1], w[2], w[3], w[4]} == "begin");
			4'd6: hit = ({w[0], w[1], w[2], w[3], w[4], w[5]} == "record");
			4'd7: hit = ({w[0], w[1], w[2], w[3], w[4], w[5], w[6]} == "declare");
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	// one token step on the front of the window
	function automatic take_res_t take(input lex_state_t s, input aln_pkg::char_t w0,
			input aln_pkg::char_t w1, input aln_pkg::char_t w2, input logic [1:0] avail);
		take_res_t      r;
		logic           go_idle;
		logic           has_sep;
		aln_pkg::char_t lc;
		aln_pkg::char_t sep;
		r       = '0;
		r.st    = s;
		r.k     = 2'd1;
		go_idle = 1'b0;
		has_sep = 1'b0;
		sep     = ChSpace;
		lc      = to_lower(w0);
		case (s.mode)
			MODE_COMMENT: begin
				if (w0 == ChNewline)
					r.st.mode = MODE_IDLE;
			end
			MODE_STRING: begin
				if (avail >= 2'd2 && w0 == ChQuote && w1 == ChQuote) begin
					r.ch[0] = w0;
					r.ch[1] = w1;
					r.n     = 2'd2;
					r.k     = 2'd2;
				end else begin
					if (w0 == ChQuote)
						r.st.mode = MODE_IDLE;
					r.ch[0] = w0;
					r.n     = 2'd1;
				end
			end
			MODE_IDENT: begin
				if (is_alpha(w0) || is_digit(w0) || w0 == ChUnder) begin
					r.ch[0] = lc;
					r.n     = 2'd1;
					if ({1'b0, s.wlen} < 5'(aln_pkg::KeywordMaxChars))
						r.st.word[s.wlen[WordIdxW-1:0]] = lc;
					if (s.wlen != 4'd15)
						r.st.wlen = s.wlen + 4'd1;
				end else begin
					r.st.prev_word = 1'b1;
					go_idle        = 1'b1;
				end
			end
			MODE_NUMBER: begin
				if (is_xdigit(w0) || w0 == ChUnder || w0 == ChHash || w0 == ChDot) begin
					r.ch[0] = lc;
					r.n     = 2'd1;
				end else begin
					r.st.prev_num = 1'b1;
					go_idle       = 1'b1;
				end
			end
			default: go_idle = 1'b1;
		endcase
		if (go_idle) begin
			r.st.mode = MODE_IDLE;
			if (avail >= 2'd2 && w0 == ChDash && w1 == ChDash) begin
				r.st.mode = MODE_COMMENT;
				r.k       = 2'd2;
			end else if (w0 == ChQuote) begin
				r.st.mode      = MODE_STRING;
				r.st.prev_word = 1'b0;
				r.st.prev_num  = 1'b0;
				r.ch[0]        = w0;
				r.n            = 2'd1;
			end else if (avail == 2'd3 && w0 == ChTick && w2 == ChTick) begin
				r.st.prev_word = 1'b0;
				r.st.prev_num  = 1'b0;
				r.ch[0]        = w0;
				r.ch[1]        = w1;
				r.ch[2]        = w2;
				r.n            = 2'd3;
				r.k            = 2'd3;
			end else if (is_alpha(w0) || is_digit(w0)) begin
				if (r.st.prev_word) begin
					has_sep        = 1'b1;
					sep            = is_keyword(s.word, s.wlen) ? ChNewline : ChSpace;
					r.st.prev_word = 1'b0;
				end else if (r.st.prev_num) begin
					has_sep       = 1'b1;
					r.st.prev_num = 1'b0;
				end
				if (has_sep) begin
					r.ch[0] = sep;
					r.ch[1] = lc;
					r.n     = 2'd2;
				end else begin
					r.ch[0] = lc;
					r.n     = 2'd1;
				end
				if (is_alpha(w0)) begin
					r.st.mode    = MODE_IDENT;
					r.st.word[0] = lc;
					r.st.wlen    = 4'd1;
				end else begin
					r.st.mode = MODE_NUMBER;
				end
			end else if (!is_space(w0)) begin
				r.st.prev_word = 1'b0;
				r.st.prev_num  = 1'b0;
				r.ch[0]        = w0;
				r.n            = 2'd1;
				if (w0 == ChSemi) begin
					r.ch[1] = ChNewline;
					r.n     = 2'd2;
				end
			end
		end
		return r;
	endfunction

	fsm_t                                       fsm_q;
	lex_mode_t                                  mode_q;
	logic                                       prev_word_q;
	logic                                       prev_num_q;
	logic [3:0]                                 wlen_q;
	word_t                                      word_q;
	aln_pkg::char_t [1:0]                       la_q;
	logic [1:0]                                 la_cnt_q;
	aln_pkg::char_t [aln_pkg::EntryChars-1:0]   acc_q;
	logic [aln_pkg::EntryCntW-1:0]              acc_cnt_q;

	lex_state_t           cur_st;
	take_res_t            tr;
	aln_pkg::char_t [2:0] wv;
	aln_pkg::char_t [1:0] la_nxt;
	logic [1:0]           avail;
	logic [1:0]           rem;
	logic                 accept;
	logic                 drain_step;
	logic                 do_take;
	logic                 last_ctx;
	logic                 finishing;
	aln_pkg::entry_t      merged;

	assign byte_stall = (fsm_q == F_DRAIN) || fifo_stat.full;
	assign accept     = byte_valid && !byte_stall;
	assign drain_step = (fsm_q == F_DRAIN) && !fifo_stat.full;
	assign last_ctx   = (fsm_q == F_DRAIN) || byte_data.last_byte;

	assign cur_st.mode      = mode_q;
	assign cur_st.prev_word = prev_word_q;
	assign cur_st.prev_num  = prev_num_q;
	assign cur_st.word      = word_q;
	assign cur_st.wlen      = wlen_q;

	always_comb begin
		if (fsm_q == F_DRAIN) begin
			wv[0] = la_q[0];
			wv[1] = la_q[1];
			wv[2] = 8'h00;
			avail = la_cnt_q;
		end else begin
			wv[0] = (la_cnt_q == 2'd0) ? byte_data.in_byte : la_q[0];
			wv[1] = (la_cnt_q == 2'd1) ? byte_data.in_byte : la_q[1];
			wv[2] = byte_data.in_byte;
			avail = la_cnt_q + 2'd1;
		end
	end

	assign tr      = take(cur_st, wv[0], wv[1], wv[2], avail);
	assign do_take = drain_step || (accept && (byte_data.last_byte || avail == 2'd3));
	assign rem     = avail - tr.k;

	always_comb begin
		case (tr.k)
			2'd1: begin
				la_nxt[0] = wv[1];
				la_nxt[1] = wv[2];
			end
			2'd2: begin
				la_nxt[0] = wv[2];
				la_nxt[1] = la_q[1];
			end
			default: la_nxt = la_q;
		endcase
	end

	// append this step's characters behind those gathered so far in the drain
	always_comb begin
		merged.ch = acc_q;
		for (int i = 0; i < aln_pkg::EntryChars; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (2'(j) < tr.n &&
				    acc_cnt_q + aln_pkg::EntryCntW'(j) == aln_pkg::EntryCntW'(i))
					merged.ch[i] = tr.ch[j];
			end
		end
		merged.cnt = acc_cnt_q + aln_pkg::EntryCntW'(tr.n);
		merged.eof = finishing;
	end

	assign finishing = do_take && last_ctx && rem == 2'd0;
	assign push      = finishing || (do_take && !last_ctx && tr.n != 2'd0);
	assign push_data = merged;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q       <= F_RUN;
			mode_q      <= MODE_IDLE;
			prev_word_q <= 1'b0;
			prev_num_q  <= 1'b0;
			wlen_q      <= '0;
			la_cnt_q    <= '0;
			acc_cnt_q   <= '0;
		end else if (do_take) begin
			if (finishing) begin
				fsm_q       <= F_RUN;
				mode_q      <= MODE_IDLE;
				prev_word_q <= 1'b0;
				prev_num_q  <= 1'b0;
				wlen_q      <= '0;
				la_cnt_q    <= '0;
				acc_cnt_q   <= '0;
			end else begin
				mode_q      <= tr.st.mode;
				prev_word_q <= tr.st.prev_word;
				prev_num_q  <= tr.st.prev_num;
				wlen_q      <= tr.st.wlen;
				la_cnt_q    <= rem;
				if (last_ctx) begin
					fsm_q     <= F_DRAIN;
					acc_cnt_q <= merged.cnt;
				end
			end
		end else if (accept) begin
			la_cnt_q <= la_cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_take) begin
			word_q <= tr.st.word;
			la_q   <= la_nxt;
			acc_q  <= merged.ch;
		end else if (accept) begin
			la_q[la_cnt_q[0]] <= byte_data.in_byte;
		end
	end

endmodule

`default_nettype wire

// ===== sv/aln_fifo.sv =====
// short queue of character groups between front and back end
// depends on aln_pkg
`timescale 1ns / 1ps
`default_nettype none

module aln_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  aln_pkg::entry_t     push_data,
	input  logic                pop,
	output aln_pkg::entry_t     head,
	output aln_pkg::fifo_stat_t fifo_stat
);

	aln_pkg::entry_t                 mem [aln_pkg::FifoDepth];
	logic [aln_pkg::FifoAw-1:0]      wr_q;
	logic [aln_pkg::FifoAw-1:0]      rd_q;
	logic [aln_pkg::FifoCntW-1:0]    cnt_q;

	assign head            = mem[rd_q];
	assign fifo_stat.full  = cnt_q == aln_pkg::FifoCntW'(aln_pkg::FifoDepth);
	assign fifo_stat.empty = cnt_q == '0;

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/aln_back.sv =====
// back end: serializes queued character groups onto the output register
// depends on aln_pkg; reads the head of aln_fifo
`timescale 1ns / 1ps
`default_nettype none

module aln_back (
	input  logic                clk,
	input  logic                arst_n,
	input  aln_pkg::entry_t     head,
	input  aln_pkg::fifo_stat_t fifo_stat,
	output logic                pop,
	output logic                lex_valid,
	input  logic                lex_stall,
	output aln_pkg::lex_item_t  lex_data
);

	logic [aln_pkg::EntryIdxW-1:0] idx_q;
	logic                          out_valid_q;
	aln_pkg::lex_item_t            out_q;

	logic               load;
	logic               last_of_entry;
	aln_pkg::lex_item_t nxt;

	assign last_of_entry = (head.cnt == '0) ||
	                       (aln_pkg::EntryCntW'(idx_q) == head.cnt - 1'b1);
	assign load = !fifo_stat.empty && (!out_valid_q || !lex_stall);
	assign pop  = load && last_of_entry;

	// empty group marks a file end with nothing to show
	always_comb begin
		nxt.char_valid  = head.cnt != '0;
		nxt.out_char    = (head.cnt != '0) ? head.ch[idx_q] : 8'h00;
		nxt.end_of_file = head.eof && last_of_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= last_of_entry ? '0 : idx_q + 1'b1;
			end else if (!lex_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			out_q <= nxt;
	end

	assign lex_valid = out_valid_q;
	assign lex_data  = out_q;

endmodule

`default_nettype wire

// ===== sv/ada_lexical_normalizer.sv =====
// top level of the ada lexical normalizer
// depends on aln_pkg, aln_front, aln_fifo and aln_back
`timescale 1ns / 1ps
`default_nettype none

// Source bytes enter on the byte channel, one per cycle while the four-word queue has room;
// the lexer holds two bytes of lookahead, so a byte's characters appear two bytes later and
// the front end classifies a full window in the cycle the byte is taken. The output register
// sends one character per cycle while lex_stall is low, so throughput is set by the output
// port. A byte marked last drains the window in one to three steps; the input stalls while
// the drain runs, and the file's last group of up to six characters, or a bare end marker,
// ends with end_of_file set.
module ada_lexical_normalizer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  aln_pkg::byte_item_t byte_data,
	output logic                lex_valid,
	input  logic                lex_stall,
	output aln_pkg::lex_item_t  lex_data
);

	aln_pkg::fifo_stat_t fifo_stat;
	aln_pkg::entry_t     push_data;
	aln_pkg::entry_t     head;
	logic                push;
	logic                pop;

	aln_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.fifo_stat  (fifo_stat),
		.push       (push),
		.push_data  (push_data)
	);

	aln_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.fifo_stat (fifo_stat)
	);

	aln_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.fifo_stat (fifo_stat),
		.pop       (pop),
		.lex_valid (lex_valid),
		.lex_stall (lex_stall),
		.lex_data  (lex_data)
	);

endmodule

`default_nettype wire

// ===== sv/aln_checker.sv =====
// port-level checks for the ada lexical normalizer, bound to the top level
// depends on aln_pkg and ada_lexical_normalizer_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "ada_lexical_normalizer_macros.svh"

module aln_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               lex_valid,
	input logic               lex_stall,
	input aln_pkg::lex_item_t lex_data
);

	// stalled output word holds
	`ALN_ASSERT_NEXT(a_out_hold, clk, arst_n, lex_valid && lex_stall, lex_valid && $stable(lex_data))

	// a word without a character is only ever the bare end marker
	`ALN_ASSERT_NOW(a_bare_end, clk, arst_n, lex_valid && !lex_data.char_valid, lex_data.end_of_file && lex_data.out_char == 8'h00)

	// nothing leaves in the first cycle out of reset
	`ALN_ASSERT_NOW(a_quiet_after_reset, clk, arst_n, $past(!arst_n), !lex_valid)

endmodule

bind ada_lexical_normalizer aln_checker u_aln_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.lex_valid (lex_valid),
	.lex_stall (lex_stall),
	.lex_data  (lex_data)
);

`default_nettype wire
